// File: sv/i2cseq_pkg.sv
// Shared types, codes and helpers for the I2C master transaction sequencer.
`default_nettype none

package i2cseq_pkg;

  localparam int unsigned QUEUE_SLOTS_DEF = 3;

  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PROBE = 2'd2,
    CMD_EVENT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ACT_REPLY    = 4'd0,
    ACT_START    = 4'd1,
    ACT_ADDR     = 4'd2,
    ACT_SEND     = 4'd3,
    ACT_RCEN     = 4'd4,
    ACT_STORE    = 4'd5,
    ACT_ACK      = 4'd6,
    ACT_STOP     = 4'd7,
    ACT_DONE     = 4'd8,
    ACT_BUSRESET = 4'd9
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SEND_ADDR  = 4'd1,
    PH_CMD_DATA   = 4'd2,
    PH_WRITE_DATA = 4'd3,
    PH_STOP       = 4'd4,
    PH_DONE       = 4'd5,
    PH_READ_START = 4'd6,
    PH_READ_ADDR  = 4'd7,
    PH_RECEN      = 4'd8,
    PH_RECSTORE   = 4'd9,
    PH_REREC      = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_FREE_WAIT,
    SQ_PEND_WAIT,
    SQ_EMIT
  } seq_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  address_byte;
    logic [7:0]  command_len;
    logic [15:0] payload_len;
    logic [7:0]  request_tag;
    logic        nack_seen;
    logic [7:0]  received_byte;
    logic        port_fault;
  } in_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  data_byte;
    logic        buffer_select;
    logic [15:0] byte_index;
    logic        ack_bit;
    logic [7:0]  tag;
    logic        flag;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        is_read;
    logic [7:0]  address;
    logic [7:0]  cmd_len;
    logic [15:0] size;
    logic [7:0]  tag;
  } slot_t;

  // control from the sequencer to the slot queue
  typedef struct packed {
    logic scan;
    logic want_free;
    logic write;
    logic take;
    logic clear;
  } sq_ctrl_t;

  typedef struct packed {
    logic done;
    logic found;
  } sq_stat_t;

  function automatic out_t mk_res(action_e act, logic [7:0] data, logic sel,
                                  logic [15:0] idx, logic ack, logic [7:0] tag,
                                  logic flag);
    out_t r;
    r.action        = act;
    r.data_byte     = data;
    r.buffer_select = sel;
    r.byte_index    = idx;
    r.ack_bit       = ack;
    r.tag           = tag;
    r.flag          = flag;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/i2cseq_slots.sv
// Request slot queue with a one-slot-per-cycle scan for the lowest free or pending slot.
`default_nettype none

module i2cseq_slots import i2cseq_pkg::*; #(
  parameter int unsigned QueueSlots = QUEUE_SLOTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sq_ctrl_t ctrl_i,
  input  wire slot_t    wdata_i,
  output sq_stat_t      stat_o,
  output slot_t         rdata_o
);

  localparam int unsigned IdxW = (QueueSlots > 1) ? $clog2(QueueSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueSlots - 1);

  logic [QueueSlots-1:0] pend_q;
  slot_t                 slot_q [QueueSlots];
  logic [IdxW-1:0]       idx_q;
  logic                  scan_q;
  logic                  free_mode_q;
  logic                  hit;
  logic                  scan_end;

  assign hit      = free_mode_q ? !pend_q[idx_q] : pend_q[idx_q];
  assign scan_end = scan_q && (hit || (idx_q == LastIdx));

  assign stat_o.done  = scan_end;
  assign stat_o.found = scan_q && hit;
  assign rdata_o      = slot_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      idx_q       <= '0;
      scan_q      <= 1'b0;
      free_mode_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        pend_q <= '0;
      end else if (ctrl_i.write) begin
        pend_q[idx_q] <= 1'b1;
      end else if (ctrl_i.take) begin
        pend_q[idx_q] <= 1'b0;
      end
      if (ctrl_i.scan) begin
        scan_q      <= 1'b1;
        idx_q       <= '0;
        free_mode_q <= ctrl_i.want_free;
      end else if (scan_q) begin
        // hold the index on the hit so the slot can be read and updated
        if (scan_end) begin
          scan_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      slot_q[idx_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer: command decode, transfer phases, results.
`default_nettype none

// An item is taken when start_i is high and busy_o is low; busy_o then stays high until the
// item's last result has been loaded into the output register. Results leave one per cycle on
// result_o, each marked by a one-cycle result_valid_o, and cannot be held off. A bus event
// that finishes a transfer, and every enqueue, add a scan of the request slots that visits
// one slot a cycle (an enqueue that finds a free slot scans twice: for a free slot, then for
// the lowest-numbered pending one). There is no clearing pass: slot valid bits clear at reset.
module i2c_master_transaction_sequencer_unit import i2cseq_pkg::*; #(
  parameter int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire in_t  item_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output out_t      result_o
);

  seq_e        state_q, state_d;
  in_t         req_q, req_d;
  phase_e      phase_q, phase_d;
  logic        port_busy_q, port_busy_d;
  logic [15:0] bc_q, bc_d;
  logic [7:0]  act_addr_q, act_addr_d;
  logic [7:0]  act_clen_q, act_clen_d;
  logic [15:0] act_wlen_q, act_wlen_d;
  logic [15:0] act_rlen_q, act_rlen_d;
  logic [7:0]  act_tag_q, act_tag_d;
  out_t        res_q [3];
  logic [1:0]  res_cnt_q, res_cnt_d;
  logic [1:0]  emit_idx_q, emit_idx_d;
  out_t        out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [1:0]  push_n;
  out_t        push_a, push_b;
  sq_ctrl_t    sq_ctrl;
  sq_stat_t    sq_stat;
  slot_t       sq_wdata;
  slot_t       sq_rdata;
  logic [15:0] bc_inc;
  logic        started;
  logic        accept;
  logic        emit_last;

  i2cseq_slots #(
    .QueueSlots(QUEUE_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .wdata_i(sq_wdata),
    .stat_o (sq_stat),
    .rdata_o(sq_rdata)
  );

  assign busy_o         = (state_q != SQ_IDLE);
  assign accept         = start_i && !busy_o;
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  assign bc_inc    = bc_q + 16'd1;
  assign started   = sq_stat.found && !req_q.port_fault && !port_busy_q;
  assign emit_last = (emit_idx_q == (res_cnt_q - 2'd1));

  assign sq_wdata.is_read = (req_q.cmd == CMD_READ);
  assign sq_wdata.address = req_q.address_byte;
  assign sq_wdata.cmd_len = req_q.command_len;
  assign sq_wdata.size    = req_q.payload_len;
  assign sq_wdata.tag     = req_q.request_tag;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_DECODE;
        end
      end
      SQ_DECODE: begin
        case (req_q.cmd)
          CMD_WRITE, CMD_READ: state_d = SQ_FREE_WAIT;
          CMD_PROBE:           state_d = SQ_EMIT;
          default: begin
            state_d = (phase_q == PH_DONE) ? SQ_PEND_WAIT : SQ_EMIT;
          end
        endcase
      end
      SQ_FREE_WAIT: begin
        if (sq_stat.done) begin
          state_d = sq_stat.found ? SQ_PEND_WAIT : SQ_EMIT;
        end
      end
      SQ_PEND_WAIT: begin
        if (sq_stat.done) begin
          state_d = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if ((res_cnt_q == 2'd0) || emit_last) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    req_d       = req_q;
    phase_d     = phase_q;
    port_busy_d = port_busy_q;
    bc_d        = bc_q;
    act_addr_d  = act_addr_q;
    act_clen_d  = act_clen_q;
    act_wlen_d  = act_wlen_q;
    act_rlen_d  = act_rlen_q;
    act_tag_d   = act_tag_q;
    res_cnt_d   = res_cnt_q;
    emit_idx_d  = emit_idx_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    push_n      = 2'd0;
    push_a      = '0;
    push_b      = '0;
    sq_ctrl     = '0;

    case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          req_d      = item_i;
          res_cnt_d  = 2'd0;
          emit_idx_d = 2'd0;
        end
      end

      SQ_DECODE: begin
        case (req_q.cmd)
          CMD_WRITE, CMD_READ: begin
            sq_ctrl.scan      = 1'b1;
            sq_ctrl.want_free = 1'b1;
          end
          CMD_PROBE: begin
            push_a = mk_res(ACT_REPLY, 8'd0, 1'b0, 16'd0, 1'b0, req_q.request_tag,
                            !req_q.port_fault && !port_busy_q);
            push_n = 2'd1;
            if (!req_q.port_fault && !port_busy_q) begin
              port_busy_d = 1'b1;
              act_tag_d   = req_q.request_tag;
              act_clen_d  = 8'd0;
              act_addr_d  = req_q.address_byte;
              act_wlen_d  = 16'd0;
              act_rlen_d  = 16'd0;
              bc_d        = 16'd0;
              phase_d     = PH_SEND_ADDR;
              push_b = mk_res(ACT_START, 8'd0, 1'b0, 16'd0, 1'b0, req_q.request_tag, 1'b0);
              push_n = 2'd2;
            end
          end
          default: begin
            case (phase_q)
              PH_SEND_ADDR: begin
                push_a  = mk_res(ACT_ADDR, act_addr_q & ADDR_WR_MASK, 1'b0, 16'd0, 1'b0,
                                 act_tag_q, 1'b0);
                push_n  = 2'd1;
                phase_d = PH_CMD_DATA;
              end
              PH_CMD_DATA, PH_WRITE_DATA: begin
                if (req_q.nack_seen) begin
                  push_a      = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                  push_b      = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                  push_n      = 2'd2;
                  phase_d     = PH_IDLE;
                  port_busy_d = 1'b0;
                end else if (phase_q == PH_CMD_DATA) begin
                  if (act_clen_q == 8'd0) begin
                    push_a  = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                    push_n  = 2'd1;
                    phase_d = PH_DONE;
                  end else begin
                    push_a = mk_res(ACT_SEND, 8'd0, 1'b0, bc_q, 1'b0, act_tag_q, 1'b0);
                    push_n = 2'd1;
                    bc_d   = bc_inc;
                    if (bc_inc >= {8'd0, act_clen_q}) begin
                      bc_d    = 16'd0;
                      phase_d = (act_rlen_q != 16'd0) ? PH_READ_START : PH_WRITE_DATA;
                    end
                  end
                end else begin
                  if (act_wlen_q == 16'd0) begin
                    push_a  = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                    push_n  = 2'd1;
                    phase_d = PH_DONE;
                  end else begin
                    push_a = mk_res(ACT_SEND, 8'd0, 1'b1, bc_q, 1'b0, act_tag_q, 1'b0);
                    push_n = 2'd1;
                    bc_d   = bc_inc;
                    if (bc_inc >= act_wlen_q) begin
                      phase_d = (act_rlen_q == 16'd0) ? PH_STOP : PH_READ_START;
                    end
                  end
                end
              end
              PH_STOP: begin
                push_a  = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                push_n  = 2'd1;
                phase_d = PH_DONE;
              end
              PH_DONE: begin
                // report success, then look for the lowest-numbered pending request
                push_a            = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b1);
                push_n            = 2'd1;
                port_busy_d       = 1'b0;
                phase_d           = PH_IDLE;
                sq_ctrl.scan      = 1'b1;
                sq_ctrl.want_free = 1'b0;
              end
              PH_READ_START: begin
                bc_d    = 16'd0;
                push_a  = mk_res(ACT_START, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                push_n  = 2'd1;
                phase_d = PH_READ_ADDR;
              end
              PH_READ_ADDR: begin
                push_a  = mk_res(ACT_ADDR, act_addr_q | ADDR_RD_BIT, 1'b0, 16'd0, 1'b0,
                                 act_tag_q, 1'b0);
                push_n  = 2'd1;
                phase_d = PH_RECEN;
              end
              PH_RECEN: begin
                if (req_q.nack_seen) begin
                  push_a      = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                  push_b      = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                  push_n      = 2'd2;
                  phase_d     = PH_IDLE;
                  port_busy_d = 1'b0;
                end else begin
                  push_a  = mk_res(ACT_RCEN, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                  push_n  = 2'd1;
                  phase_d = PH_RECSTORE;
                end
              end
              PH_RECSTORE: begin
                push_a = mk_res(ACT_STORE, req_q.received_byte, 1'b0, bc_q, 1'b0,
                                act_tag_q, 1'b0);
                push_b = mk_res(ACT_ACK, 8'd0, 1'b0, 16'd0, bc_inc >= act_rlen_q,
                                act_tag_q, 1'b0);
                push_n  = 2'd2;
                bc_d    = bc_inc;
                phase_d = (bc_inc >= act_rlen_q) ? PH_STOP : PH_REREC;
              end
              PH_REREC: begin
                push_a  = mk_res(ACT_RCEN, 8'd0, 1'b0, 16'd0, 1'b0, act_tag_q, 1'b0);
                push_n  = 2'd1;
                phase_d = PH_RECSTORE;
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        endcase
      end

      SQ_FREE_WAIT: begin
        if (sq_stat.done) begin
          if (sq_stat.found) begin
            sq_ctrl.write     = 1'b1;
            sq_ctrl.scan      = 1'b1;
            sq_ctrl.want_free = 1'b0;
          end else begin
            // queue full: drop the request and reset the bus
            sq_ctrl.clear = 1'b1;
            phase_d       = PH_IDLE;
            port_busy_d   = 1'b0;
            push_a = mk_res(ACT_BUSRESET, 8'd0, 1'b0, 16'd0, 1'b0, req_q.request_tag, 1'b0);
            push_b = mk_res(ACT_REPLY, 8'd0, 1'b0, 16'd0, 1'b0, req_q.request_tag, 1'b0);
            push_n = 2'd2;
          end
        end
      end

      SQ_PEND_WAIT: begin
        if (sq_stat.done) begin
          if (started) begin
            sq_ctrl.take = 1'b1;
            port_busy_d  = 1'b1;
            act_tag_d    = sq_rdata.tag;
            act_clen_d   = sq_rdata.cmd_len;
            act_addr_d   = sq_rdata.address;
            act_wlen_d   = sq_rdata.is_read ? 16'd0 : sq_rdata.size;
            act_rlen_d   = sq_rdata.is_read ? sq_rdata.size : 16'd0;
            bc_d         = 16'd0;
            phase_d      = PH_SEND_ADDR;
          end
          if (req_q.cmd == CMD_EVENT) begin
            push_a = mk_res(ACT_START, 8'd0, 1'b0, 16'd0, 1'b0, sq_rdata.tag, 1'b0);
            push_n = started ? 2'd1 : 2'd0;
          end else begin
            push_a = mk_res(ACT_REPLY, 8'd0, 1'b0, 16'd0, 1'b0, req_q.request_tag, started);
            push_b = mk_res(ACT_START, 8'd0, 1'b0, 16'd0, 1'b0, sq_rdata.tag, 1'b0);
            push_n = started ? 2'd2 : 2'd1;
          end
        end
      end

      SQ_EMIT: begin
        if (res_cnt_q != 2'd0) begin
          out_d       = res_q[emit_idx_q];
          out_d.last  = emit_last;
          out_valid_d = 1'b1;
          emit_idx_d  = emit_idx_q + 2'd1;
        end
      end

      default: ;
    endcase

    res_cnt_d = res_cnt_d + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      phase_q     <= PH_IDLE;
      port_busy_q <= 1'b0;
      bc_q        <= 16'd0;
      act_addr_q  <= 8'd0;
      act_clen_q  <= 8'd0;
      act_wlen_q  <= 16'd0;
      act_rlen_q  <= 16'd0;
      act_tag_q   <= 8'd0;
      res_cnt_q   <= 2'd0;
      emit_idx_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      port_busy_q <= port_busy_d;
      bc_q        <= bc_d;
      act_addr_q  <= act_addr_d;
      act_clen_q  <= act_clen_d;
      act_wlen_q  <= act_wlen_d;
      act_rlen_q  <= act_rlen_d;
      act_tag_q   <= act_tag_d;
      res_cnt_q   <= res_cnt_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
    if (push_n != 2'd0) begin
      res_q[res_cnt_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      res_q[res_cnt_q + 2'd1] <= push_b;
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the I2C master transaction sequencer unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam int unsigned ITEM_TARGET   = 260;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    in_t         stim;
    int unsigned n_typed;
    out_t        typed_a;
    out_t        typed_b;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic result_valid_o;
  out_t result_o;

  // typed results that replace the predicted ones for the item being driven
  int unsigned fix_cnt;
  out_t        fix_a;
  out_t        fix_b;

  // predictor state
  phase_e      ph;
  logic        link_busy;
  logic [15:0] byte_cnt;
  logic [7:0]  cur_addr;
  logic [7:0]  cur_clen;
  logic [15:0] cur_wlen;
  logic [15:0] cur_rlen;
  logic [7:0]  cur_tag;
  logic        slot_pend [QUEUE_SLOTS_DEF];
  slot_t       slot_req  [QUEUE_SLOTS_DEF];

  out_t        action_q [$];
  plan_row_t   plan [$];
  int unsigned bad_results;
  int unsigned useful_items;
  int unsigned stall_cycles;
  bit          steady;

  i2c_master_transaction_sequencer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic out_t pack_action(action_e a, logic [7:0] d, logic sel,
                                       logic [15:0] idx, logic ack, logic [7:0] tg,
                                       logic fl, logic lst);
    out_t r;
    r.action        = a;
    r.data_byte     = d;
    r.buffer_select = sel;
    r.byte_index    = idx;
    r.ack_bit       = ack;
    r.tag           = tg;
    r.flag          = fl;
    r.last          = lst;
    return r;
  endfunction

  function automatic void add_action(action_e a, logic [7:0] d, logic sel,
                                     logic [15:0] idx, logic ack, logic [7:0] tg,
                                     logic fl);
    action_q.push_back(pack_action(a, d, sel, idx, ack, tg, fl, 1'b0));
  endfunction

  function automatic void clear_model();
    ph        = PH_IDLE;
    link_busy = 1'b0;
    byte_cnt  = '0;
    cur_addr  = '0;
    cur_clen  = '0;
    cur_wlen  = '0;
    cur_rlen  = '0;
    cur_tag   = '0;
    for (int i = 0; i < QUEUE_SLOTS_DEF; i++) begin
      slot_pend[i] = 1'b0;
      slot_req[i]  = '0;
    end
  endfunction

  // Start the lowest-numbered pending request if the port is free and healthy.
  function automatic bit launch_pending(logic fault);
    for (int i = 0; i < QUEUE_SLOTS_DEF; i++) begin
      if (slot_pend[i]) begin
        if (fault || link_busy) return 1'b0;
        link_busy    = 1'b1;
        slot_pend[i] = 1'b0;
        cur_tag      = slot_req[i].tag;
        cur_clen     = slot_req[i].cmd_len;
        cur_addr     = slot_req[i].address;
        cur_wlen     = slot_req[i].is_read ? 16'd0 : slot_req[i].size;
        cur_rlen     = slot_req[i].is_read ? slot_req[i].size : 16'd0;
        byte_cnt     = '0;
        ph           = PH_SEND_ADDR;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void abort_transfer();
    ph        = PH_IDLE;
    link_busy = 1'b0;
    add_action(ACT_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
    add_action(ACT_DONE, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
  endfunction

  // Advance the predictor by one accepted item and queue the bus actions it causes.
  function automatic void step_sequencer(in_t it);
    int unsigned n0;
    int          free_idx;
    bit          started;
    out_t        tail;
    n0       = action_q.size();
    free_idx = -1;
    case (it.cmd)
      CMD_WRITE, CMD_READ: begin
        for (int i = 0; i < QUEUE_SLOTS_DEF; i++)
          if (!slot_pend[i] && free_idx < 0) free_idx = i;
        if (free_idx < 0) begin
          for (int i = 0; i < QUEUE_SLOTS_DEF; i++) slot_pend[i] = 1'b0;
          ph        = PH_IDLE;
          link_busy = 1'b0;
          add_action(ACT_BUSRESET, 8'h00, 1'b0, 16'h0000, 1'b0, it.request_tag, 1'b0);
          add_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, it.request_tag, 1'b0);
        end else begin
          slot_pend[free_idx]        = 1'b1;
          slot_req[free_idx].is_read = (it.cmd == CMD_READ);
          slot_req[free_idx].address = it.address_byte;
          slot_req[free_idx].cmd_len = it.command_len;
          slot_req[free_idx].size    = it.payload_len;
          slot_req[free_idx].tag     = it.request_tag;
          started = launch_pending(it.port_fault);
          add_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, it.request_tag, started);
          if (started) add_action(ACT_START, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
        end
      end
      CMD_PROBE: begin
        started = !it.port_fault && !link_busy;
        if (started) begin
          link_busy = 1'b1;
          cur_tag   = it.request_tag;
          cur_clen  = '0;
          cur_addr  = it.address_byte;
          cur_wlen  = '0;
          cur_rlen  = '0;
          byte_cnt  = '0;
          ph        = PH_SEND_ADDR;
        end
        add_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, it.request_tag, started);
        if (started) add_action(ACT_START, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
      end
      default: begin
        case (ph)
          PH_SEND_ADDR: begin
            add_action(ACT_ADDR, cur_addr & ADDR_WR_MASK, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
            ph = PH_CMD_DATA;
          end
          PH_CMD_DATA: begin
            if (it.nack_seen) abort_transfer();
            else if (cur_clen == 8'd0) begin
              // no command bytes: the transfer ends right after the address
              add_action(ACT_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
              ph = PH_DONE;
            end else begin
              add_action(ACT_SEND, 8'h00, 1'b0, byte_cnt, 1'b0, cur_tag, 1'b0);
              byte_cnt = byte_cnt + 16'd1;
              if (byte_cnt >= {8'd0, cur_clen}) begin
                byte_cnt = '0;
                ph = (cur_rlen > 0) ? PH_READ_START : PH_WRITE_DATA;
              end
            end
          end
          PH_WRITE_DATA: begin
            if (it.nack_seen) abort_transfer();
            else if (cur_wlen == 16'd0) begin
              add_action(ACT_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
              ph = PH_DONE;
            end else begin
              add_action(ACT_SEND, 8'h00, 1'b1, byte_cnt, 1'b0, cur_tag, 1'b0);
              byte_cnt = byte_cnt + 16'd1;
              if (byte_cnt >= cur_wlen) ph = (cur_rlen == 0) ? PH_STOP : PH_READ_START;
            end
          end
          PH_STOP: begin
            add_action(ACT_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
            ph = PH_DONE;
          end
          PH_DONE: begin
            link_busy = 1'b0;
            ph        = PH_IDLE;
            add_action(ACT_DONE, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b1);
            if (launch_pending(it.port_fault))
              add_action(ACT_START, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
          end
          PH_READ_START: begin
            byte_cnt = '0;
            add_action(ACT_START, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
            ph = PH_READ_ADDR;
          end
          PH_READ_ADDR: begin
            add_action(ACT_ADDR, cur_addr | ADDR_RD_BIT, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
            ph = PH_RECEN;
          end
          PH_RECEN: begin
            if (it.nack_seen) abort_transfer();
            else begin
              add_action(ACT_RCEN, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
              ph = PH_RECSTORE;
            end
          end
          PH_RECSTORE: begin
            add_action(ACT_STORE, it.received_byte, 1'b0, byte_cnt, 1'b0, cur_tag, 1'b0);
            byte_cnt = byte_cnt + 16'd1;
            // NACK the final byte of the read
            if (byte_cnt >= cur_rlen) begin
              add_action(ACT_ACK, 8'h00, 1'b0, 16'h0000, 1'b1, cur_tag, 1'b0);
              ph = PH_STOP;
            end else begin
              add_action(ACT_ACK, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
              ph = PH_REREC;
            end
          end
          PH_REREC: begin
            add_action(ACT_RCEN, 8'h00, 1'b0, 16'h0000, 1'b0, cur_tag, 1'b0);
            ph = PH_RECSTORE;
          end
          default: ph = PH_IDLE;
        endcase
      end
    endcase
    if (action_q.size() > n0) begin
      tail = action_q.pop_back();
      tail.last = 1'b1;
      action_q.push_back(tail);
    end
  endfunction

  function automatic string show(out_t r);
    return $sformatf("act=%0d data=%02h sel=%0b idx=%0d ack=%0b tag=%02h flag=%0b last=%0b",
                     r.action, r.data_byte, r.buffer_select, r.byte_index, r.ack_bit,
                     r.tag, r.flag, r.last);
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (action_q.size() == 0) begin
      bad_results++;
      if (bad_results <= MAX_REPORTS) $display("unexpected result: %s", show(got));
      return;
    end
    want = action_q.pop_front();
    if (got.action !== want.action || got.data_byte !== want.data_byte ||
        got.buffer_select !== want.buffer_select || got.byte_index !== want.byte_index ||
        got.ack_bit !== want.ack_bit || got.tag !== want.tag ||
        got.flag !== want.flag || got.last !== want.last) begin
      bad_results++;
      if (bad_results <= MAX_REPORTS) begin
        $display("mismatch at %0t: expected %s", $realtime, show(want));
        $display("                 actual   %s", show(got));
      end
    end
  endfunction

  // Compare results, then predict for the item accepted at this edge.
  always @(posedge clk_i) begin : monitor
    int unsigned n0;
    if (rst_ni) begin
      if (result_valid_o) check_result(result_o);
      if (start_i && !busy_o) begin
        n0 = action_q.size();
        step_sequencer(item_i);
        if (fix_cnt != 0) begin
          while (action_q.size() > n0) void'(action_q.pop_back());
          action_q.push_back(fix_a);
          if (fix_cnt > 1) action_q.push_back(fix_b);
        end
        if (action_q.size() > n0) useful_items++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_t make_item(cmd_e c, logic [7:0] addr, logic [7:0] clen,
                                    logic [15:0] plen, logic [7:0] tg, logic nack,
                                    logic [7:0] rx, logic fault);
    in_t s;
    s.cmd           = c;
    s.address_byte  = addr;
    s.command_len   = clen;
    s.payload_len   = plen;
    s.request_tag   = tg;
    s.nack_seen     = nack;
    s.received_byte = rx;
    s.port_fault    = fault;
    return s;
  endfunction

  function automatic plan_row_t plan_row(in_t s, int unsigned n, out_t a = '0, out_t b = '0);
    plan_row_t r;
    r.stim    = s;
    r.n_typed = n;
    r.typed_a = a;
    r.typed_b = b;
    return r;
  endfunction

  // Bus event with random content in the fields it does not use.
  function automatic in_t rand_event();
    return make_item(CMD_EVENT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 99) < 5, 8'($urandom_range(0, 255)),
                     $urandom_range(0, 99) < 12);
  endfunction

  function automatic in_t rand_request();
    in_t         s;
    int unsigned r;
    r = $urandom_range(0, 99);
    s = rand_event();
    s.port_fault = ($urandom_range(0, 99) < 15);
    if (r < 38) s.cmd = CMD_WRITE;
    else if (r < 76) s.cmd = CMD_READ;
    else s.cmd = CMD_PROBE;
    // keep served transfers short; probes carry full-range lengths
    if (s.cmd != CMD_PROBE) begin
      s.command_len = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(3, 6)
                                                     : $urandom_range(0, 2));
      s.payload_len = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(5, 9)
                                                      : $urandom_range(0, 4));
    end
    return s;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input in_t s, input int unsigned n, input out_t a, input out_t b);
    repeat (idle_gap()) @(posedge clk_i);
    @(posedge clk_i);
    start_i <= 1'b1;
    item_i  <= s;
    fix_cnt <= n;
    fix_a   <= a;
    fix_b   <= b;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    // let the predictor settle before the next item is chosen
    @(negedge clk_i);
  endtask

  task automatic drain_actions();
    while (action_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned guard;
    int unsigned next_drain;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    fix_cnt      = 0;
    fix_a        = '0;
    fix_b        = '0;
    bad_results  = 0;
    useful_items = 0;
    steady       = 1'b0;
    clear_model();

    // event while idle, probes, address NACK abort
    plan.push_back(plan_row(make_item(CMD_EVENT, 8'h3C, 8'hFF, 16'hFFFF, 8'hFF,
                                      1'b1, 8'hAA, 1'b1), 0));
    plan.push_back(plan_row(make_item(CMD_PROBE, 8'h00, 8'h00, 16'h0000, 8'h00,
                                      1'b0, 8'h00, 1'b1), 1,
      pack_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1)));
    plan.push_back(plan_row(make_item(CMD_PROBE, 8'hFF, 8'h00, 16'h0000, 8'hFF,
                                      1'b0, 8'h00, 1'b0), 2,
      pack_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hFF, 1'b1, 1'b0),
      pack_action(ACT_START, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0, 1'b1)));
    plan.push_back(plan_row(make_item(CMD_EVENT, 8'h00, 8'h00, 16'h0000, 8'h00,
                                      1'b0, 8'h00, 1'b0), 1,
      pack_action(ACT_ADDR, 8'hFE, 1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0, 1'b1)));
    plan.push_back(plan_row(make_item(CMD_EVENT, 8'h00, 8'h00, 16'h0000, 8'h00,
                                      1'b1, 8'h00, 1'b0), 2,
      pack_action(ACT_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0, 1'b0),
      pack_action(ACT_DONE, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0, 1'b1)));
    // write queued under a port fault, then a read that kicks it off
    plan.push_back(plan_row(make_item(CMD_WRITE, 8'h00, 8'h00, 16'hFFFF, 8'h01,
                                      1'b0, 8'h00, 1'b1), 1,
      pack_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, 8'h01, 1'b0, 1'b1)));
    plan.push_back(plan_row(make_item(CMD_READ, 8'hA1, 8'h02, 16'h0002, 8'h80,
                                      1'b0, 8'h00, 1'b0), 0));
    // zero command bytes on the write, then the full read with two bytes
    for (int i = 0; i < 14; i++)
      plan.push_back(plan_row(make_item(CMD_EVENT, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0,
                                        (i == 9) ? 8'hFF : 8'h00, 1'b0), 0));
    // fill every slot under a fault, then overflow the queue
    for (int i = 0; i < QUEUE_SLOTS_DEF; i++)
      plan.push_back(plan_row(make_item(CMD_WRITE, 8'hFF, 8'hFF, 16'hFFFF, 8'(16 + i),
                                        1'b1, 8'hFF, 1'b1), 0));
    plan.push_back(plan_row(make_item(CMD_READ, 8'h7F, 8'hFF, 16'hFFFF, 8'hEE,
                                      1'b0, 8'h00, 1'b0), 2,
      pack_action(ACT_BUSRESET, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hEE, 1'b0, 1'b0),
      pack_action(ACT_REPLY, 8'h00, 1'b0, 16'h0000, 1'b0, 8'hEE, 1'b0, 1'b1)));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_item(plan[i].stim, plan[i].n_typed, plan[i].typed_a, plan[i].typed_b);

    next_drain = 100;
    while (useful_items < ITEM_TARGET) begin
      if (useful_items >= next_drain) begin
        // hold off until the bus has caught up
        drain_actions();
        next_drain += 90;
      end
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 8) send_item(rand_event(), 0, '0, '0);
      else begin
        send_item(rand_request(), 0, '0, '0);
        guard = 0;
        while (ph != PH_IDLE && guard < 80) begin
          // occasionally queue another request mid-transfer
          if ($urandom_range(0, 99) < 7) send_item(rand_request(), 0, '0, '0);
          else send_item(rand_event(), 0, '0, '0);
          guard++;
        end
      end
    end

    drain_actions();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_results == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/i2cseq_pkg.sv
sv/i2cseq_slots.sv
sv/i2c_master_transaction_sequencer_unit.sv
bench/testbench.sv
